// ----- rtl/wla_pkg.sv -----
`default_nettype none

package wla_pkg;

    localparam int TAPS      = 11;
    localparam int AVG_BITS  = 22;
    localparam int FILL_BITS = 4;
    localparam int WGT_BITS  = 8;
    localparam int TOT_BITS  = 8;
    localparam int STEP_BITS = 3;

    localparam logic [FILL_BITS-1:0] LAST_POS  = 4'(TAPS - 1);
    localparam logic [FILL_BITS-1:0] FULL_FILL = 4'(TAPS);

    // datapath operations
    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_IDLE = 3'd1;
    localparam logic [2:0] OP_READ = 3'd2;
    localparam logic [2:0] OP_MAC  = 3'd3;
    localparam logic [2:0] OP_ABS  = 3'd4;
    localparam logic [2:0] OP_DIV  = 3'd5;
    localparam logic [2:0] OP_DONE = 3'd6;

    // jump conditions
    localparam logic [2:0] COND_NONE      = 3'd0;
    localparam logic [2:0] COND_ALWAYS    = 3'd1;
    localparam logic [2:0] COND_NO_REQ    = 3'd2;
    localparam logic [2:0] COND_MORE_TAPS = 3'd3;
    localparam logic [2:0] COND_DIV_MORE  = 3'd4;
    localparam logic [2:0] COND_OUT_BUSY  = 3'd5;

    // program addresses
    localparam logic [STEP_BITS-1:0] STEP_IDLE = 3'd0;
    localparam logic [STEP_BITS-1:0] STEP_READ = 3'd1;
    localparam logic [STEP_BITS-1:0] STEP_MAC  = 3'd2;
    localparam logic [STEP_BITS-1:0] STEP_ABS  = 3'd3;
    localparam logic [STEP_BITS-1:0] STEP_DIV  = 3'd4;
    localparam logic [STEP_BITS-1:0] STEP_DONE = 3'd5;
    localparam logic [STEP_BITS-1:0] STEP_BACK = 3'd6;

    typedef struct packed {
        logic [2:0]           op;
        logic [2:0]           cond;
        logic [STEP_BITS-1:0] target;
    } ctrl_word_t;

    function automatic ctrl_word_t prog_rom(input logic [STEP_BITS-1:0] step);
        ctrl_word_t w;
        case (step)
            STEP_IDLE: w = '{op: OP_IDLE, cond: COND_NO_REQ,    target: STEP_IDLE};
            STEP_READ: w = '{op: OP_READ, cond: COND_NONE,      target: STEP_IDLE};
            STEP_MAC:  w = '{op: OP_MAC,  cond: COND_MORE_TAPS, target: STEP_MAC};
            STEP_ABS:  w = '{op: OP_ABS,  cond: COND_NONE,      target: STEP_IDLE};
            STEP_DIV:  w = '{op: OP_DIV,  cond: COND_DIV_MORE,  target: STEP_DIV};
            STEP_DONE: w = '{op: OP_DONE, cond: COND_OUT_BUSY,  target: STEP_DONE};
            default:   w = '{op: OP_NOP,  cond: COND_ALWAYS,    target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // weight of tap k, newest sample first
    function automatic logic signed [WGT_BITS-1:0] tap_weight(input logic [FILL_BITS-1:0] k);
        logic signed [WGT_BITS-1:0] w;
        case (k)
            4'd0:    w = 8'sd60;
            4'd1:    w = 8'sd57;
            4'd2:    w = 8'sd47;
            4'd3:    w = 8'sd33;
            4'd4:    w = 8'sd18;
            4'd5:    w = 8'sd6;
            4'd6:    w = -8'sd2;
            4'd7:    w = -8'sd5;
            4'd8:    w = -8'sd5;
            4'd9:    w = -8'sd3;
            4'd10:   w = -8'sd1;
            default: w = 8'sd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/weighted_latency_average.sv -----
`default_nettype none

// Weighted moving average of latency samples over an eleven-entry ring. Each
// accepted request stores its sample, then a small microcoded sequencer runs one
// shared multiply-accumulate over the stored samples, newest first, one ring
// entry per cycle, and a restoring divider that produces one quotient bit per
// cycle divides by the sum of the weights used. The average truncates toward
// zero and fill_count tells how many samples went into it. From the accepted
// request until the sequencer is back in its idle step, further requests are
// stalled. The result sits in an output register, so the next request can be
// taken while that result is still stalled.
module weighted_latency_average #(
    parameter int SAMPLE_BITS = 20
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                sample_valid,
    output logic                               sample_stall,
    input  wire  [SAMPLE_BITS-1:0]             sample,
    output logic                               result_valid,
    input  wire                                result_stall,
    output logic signed [wla_pkg::AVG_BITS-1:0] average,
    output logic [wla_pkg::FILL_BITS-1:0]      fill_count
);
    import wla_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + 9;
    localparam int DVD_W = SAMPLE_BITS + 8;
    localparam int DCW   = $clog2(DVD_W);
    localparam int RES_W = (DVD_W + 1 > AVG_BITS) ? DVD_W + 1 : AVG_BITS;

    logic [SAMPLE_BITS-1:0] mem [TAPS];

    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [FILL_BITS-1:0]   wp_reg, wp_next;
    logic [FILL_BITS-1:0]   count_reg, count_next;
    logic                   result_valid_reg, result_valid_next;

    logic [FILL_BITS-1:0]   rd_pos_reg, rd_pos_next;
    logic [FILL_BITS-1:0]   tap_cnt_reg, tap_cnt_next;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [TOT_BITS-1:0]    total_reg, total_next;
    logic [DVD_W-1:0]       dvd_reg, dvd_next;
    logic [TOT_BITS-1:0]    rem_reg, rem_next;
    logic [DCW-1:0]         div_cnt_reg, div_cnt_next;
    logic                   neg_reg, neg_next;
    logic signed [AVG_BITS-1:0] average_reg, average_next;
    logic [FILL_BITS-1:0]   fill_reg, fill_next;

    ctrl_word_t              cw;
    logic                    accept;
    logic                    out_free;
    logic                    jump;
    logic [FILL_BITS-1:0]    pos_dec;
    logic signed [WGT_BITS-1:0] weight;
    logic signed [ACC_W-1:0] product;
    logic signed [ACC_W-1:0] acc_mag;
    logic [TOT_BITS:0]       rem_shift;
    logic                    rem_ge;
    logic [RES_W-1:0]        quot_ext;
    logic [RES_W-1:0]        result_signed;

    assign cw           = prog_rom(step_reg);
    assign sample_stall = (cw.op != OP_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign average      = average_reg;
    assign fill_count   = fill_reg;

    assign pos_dec   = (rd_pos_reg == '0) ? LAST_POS : rd_pos_reg - 4'd1;
    assign weight    = tap_weight(tap_cnt_reg);
    assign product   = ACC_W'($signed({1'b0, rd_data_reg})) * ACC_W'(weight);
    assign acc_mag   = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, total_reg});
    assign quot_ext  = RES_W'(dvd_reg);
    assign result_signed = neg_reg ? -quot_ext : quot_ext;

    always_comb
    begin
        case (cw.cond)
            COND_NONE:      jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_REQ:    jump = !sample_valid;
            COND_MORE_TAPS: jump = ((tap_cnt_reg + 4'd1) != count_reg);
            COND_DIV_MORE:  jump = (div_cnt_reg != '0);
            COND_OUT_BUSY:  jump = !out_free;
            default:        jump = 1'b0;
        endcase
        step_next = jump ? cw.target : step_reg + 3'd1;
    end

    always_comb
    begin
        wp_next           = wp_reg;
        count_next        = count_reg;
        result_valid_next = result_valid_reg && result_stall;
        rd_pos_next       = rd_pos_reg;
        tap_cnt_next      = tap_cnt_reg;
        acc_next          = acc_reg;
        total_next        = total_reg;
        dvd_next          = dvd_reg;
        rem_next          = rem_reg;
        div_cnt_next      = div_cnt_reg;
        neg_next          = neg_reg;
        average_next      = average_reg;
        fill_next         = fill_reg;
        case (cw.op)
            OP_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg == '0)
                    begin
                        wp_next    = '0;
                        count_next = 4'd1;
                    end
                    else
                    begin
                        wp_next    = (wp_reg >= LAST_POS) ? '0 : wp_reg + 4'd1;
                        count_next = (count_reg < FULL_FILL) ? count_reg + 4'd1 : FULL_FILL;
                    end
                    rd_pos_next  = wp_next;
                    tap_cnt_next = '0;
                    acc_next     = '0;
                    total_next   = '0;
                end
            end
            OP_READ:
            begin
                rd_pos_next = pos_dec;
            end
            OP_MAC:
            begin
                acc_next     = acc_reg + product;
                total_next   = total_reg + TOT_BITS'(weight);
                tap_cnt_next = tap_cnt_reg + 4'd1;
                rd_pos_next  = pos_dec;
            end
            OP_ABS:
            begin
                neg_next     = acc_reg[ACC_W-1];
                dvd_next     = acc_mag[DVD_W-1:0];
                rem_next     = '0;
                div_cnt_next = DCW'(DVD_W - 1);
            end
            OP_DIV:
            begin
                rem_next     = rem_ge ? TOT_BITS'(rem_shift - {1'b0, total_reg})
                                      : rem_shift[TOT_BITS-1:0];
                dvd_next     = {dvd_reg[DVD_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            OP_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    average_next      = result_signed[AVG_BITS-1:0];
                    fill_next         = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= STEP_IDLE;
            wp_reg           <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            wp_reg           <= wp_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg  <= rd_pos_next;
        tap_cnt_reg <= tap_cnt_next;
        acc_reg     <= acc_next;
        total_reg   <= total_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        neg_reg     <= neg_next;
        average_reg <= average_next;
        fill_reg    <= fill_next;
    end

    // ring storage, registered read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wp_next] <= sample;
        end
        rd_data_reg <= mem[rd_pos_reg];
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= FULL_FILL) && (wp_reg <= LAST_POS))
        else $error("ring count or position out of range");

    a_mac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == OP_MAC) |-> (tap_cnt_reg < count_reg))
        else $error("accumulate past the stored samples");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(cw.op == OP_DONE))
        else $error("result raised outside the done step");

    a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (acc_reg == '0) && (total_reg == '0) && (tap_cnt_reg == '0)
                   && (rd_pos_reg == wp_reg))
        else $error("accumulator not set up after a request");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (fill_reg != '0) && (fill_reg <= FULL_FILL))
        else $error("fill count out of range");

endmodule

`default_nettype wire

// ----- tb/weighted_latency_average_tb.sv -----
`default_nettype none

module weighted_latency_average_tb;

    import wla_pkg::*;

    localparam int SAMPLE_W = 20;
    localparam int DIRECTED_MAX = (1 << SAMPLE_W) - 1;
    localparam int NEWEST_FIRST_WEIGHT [TAPS] = '{60, 57, 47, 33, 18, 6, -2, -5, -5, -3, -1};
    localparam int RANDOM_REQUESTS = 1250;

    typedef struct {
        logic [SAMPLE_W-1:0] value;
        bit                  wait_drain;
    } latency_req_t;

    typedef struct {
        logic signed [AVG_BITS-1:0] average;
        logic [FILL_BITS-1:0]       fill;
    } weighted_avg_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic [SAMPLE_W-1:0]        sample = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic signed [AVG_BITS-1:0] average;
    logic [FILL_BITS-1:0]       fill_count;

    latency_req_t        pending_samples [$];
    weighted_avg_t       awaited_averages [$];
    logic [SAMPLE_W-1:0] latency_ring [TAPS];
    int                  ring_head = 0;
    int                  ring_fill = 0;
    int                  errors = 0;
    bit                  req_taken = 1'b0;
    int                  burst_left = 1;
    int                  gap_left = 0;
    int                  stall_mode = 0;
    int                  stall_timer = 0;
    int                  cycle_count = 0;

    weighted_latency_average dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .average      (average),
        .fill_count   (fill_count)
    );

    always #2 clk = ~clk;

    // store the new sample and form the normalised weighted sum, newest first
    function automatic weighted_avg_t store_and_average(input logic [SAMPLE_W-1:0] s);
        weighted_avg_t r;
        longint        acc;
        longint        wsum;
        longint        q;
        int            pos;
        if (ring_fill == 0)
        begin
            ring_head = 0;
            ring_fill = 1;
        end
        else
        begin
            ring_head = (ring_head == TAPS - 1) ? 0 : ring_head + 1;
            if (ring_fill < TAPS)
                ring_fill++;
        end
        latency_ring[ring_head] = s;
        acc  = 0;
        wsum = 0;
        pos  = ring_head;
        for (int k = 0; k < ring_fill; k++)
        begin
            acc  += longint'(NEWEST_FIRST_WEIGHT[k]) * longint'(latency_ring[pos]);
            wsum += longint'(NEWEST_FIRST_WEIGHT[k]);
            pos   = (pos == 0) ? TAPS - 1 : pos - 1;
        end
        q = acc / wsum;
        r.average = q[AVG_BITS-1:0];
        r.fill    = FILL_BITS'(ring_fill);
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_latency();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = SAMPLE_W'($urandom_range(0, 255));
            1:       v = SAMPLE_W'(DIRECTED_MAX - $urandom_range(0, 255));
            2:       v = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
            3:       v = ($urandom_range(0, 1) != 0) ? SAMPLE_W'(DIRECTED_MAX) : '0;
            default: v = SAMPLE_W'($urandom_range(0, DIRECTED_MAX));
        endcase
        return v;
    endfunction

    function automatic void queue_sample(input logic [SAMPLE_W-1:0] v, input bit drain);
        latency_req_t r;
        r.value      = v;
        r.wait_drain = drain;
        pending_samples.push_back(r);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!sample_valid || req_taken))
        begin
            if (sample_valid)
            begin
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
                end
            end
            else if (gap_left > 0)
                gap_left--;
            if (gap_left == 0 && pending_samples.size() != 0 &&
                (!pending_samples[0].wait_drain || awaited_averages.size() == 0))
            begin
                sample       <= pending_samples[0].value;
                sample_valid <= 1'b1;
                void'(pending_samples.pop_front());
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // result stall pattern
    always @(negedge clk)
    begin
        cycle_count++;
        if (stall_timer == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(50, 400);
        end
        else
            stall_timer--;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= 1'($urandom_range(0, 1));
            2:       result_stall <= ($urandom_range(0, 15) != 0);
            default: result_stall <= ((cycle_count % 7) < 3);
        endcase
    end

    // monitor
    always @(posedge clk)
    begin
        weighted_avg_t exp_r;
        req_taken <= sample_valid && !sample_stall;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_averages.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, got average %0d fill %0d",
                             $time, average, fill_count);
                    errors++;
                end
                else
                begin
                    exp_r = awaited_averages.pop_front();
                    if (average !== exp_r.average)
                    begin
                        $display("%0t average mismatch: expected %0d, got %0d",
                                 $time, exp_r.average, average);
                        errors++;
                    end
                    if (fill_count !== exp_r.fill)
                    begin
                        $display("%0t fill_count mismatch: expected %0d, got %0d",
                                 $time, exp_r.fill, fill_count);
                        errors++;
                    end
                end
            end
            if (sample_valid && !sample_stall)
                awaited_averages.push_back(store_and_average(sample));
        end
    end

    initial
    begin
        // first sample at full scale, then a ring of old maxima under new zeros
        // (most negative average), wrap-around, then new maxima over old zeros
        for (int i = 0; i < 5; i++)
            queue_sample(SAMPLE_W'(DIRECTED_MAX), 1'b0);
        for (int i = 0; i < 11; i++)
            queue_sample('0, 1'b0);
        for (int i = 0; i < 6; i++)
            queue_sample(SAMPLE_W'(DIRECTED_MAX), 1'b0);
        queue_sample(SAMPLE_W'(1), 1'b0);
        queue_sample(SAMPLE_W'(DIRECTED_MAX), 1'b0);
        for (int i = 0; i < RANDOM_REQUESTS; i++)
            queue_sample(pick_latency(), (i == 0) || (i == RANDOM_REQUESTS / 2) ||
                         ($urandom_range(0, 99) == 0));
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (pending_samples.size() != 0 || sample_valid || awaited_averages.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
